FILE: src/lmdd_pkg.sv
// ============================================================================
// lmdd_pkg: shared types and constants for the layered MDD lookup
// Field widths, table geometry, op codes and controller/datapath structs.
// ============================================================================
package lmdd_pkg;

    // Diagram geometry
    localparam int LAYERS          = 10;
    localparam int NODES_PER_LAYER = 4096;
    localparam int TRANS_PER_LAYER = 16384;
    localparam int SYMBOL_BITS     = 6;
    localparam int ROW_STRIDE      = 6;

    // Item and result field widths
    localparam int OP_W     = 2;
    localparam int LAYER_W  = 4;
    localparam int ENTRY_W  = 14;
    localparam int OFFSET_W = 14;
    localparam int LENGTH_W = 15;
    localparam int WORD_W   = 32;
    localparam int POS_W    = LAYERS * ROW_STRIDE;
    localparam int FAIL_W   = $clog2(LAYERS + 1);

    // Storage geometry
    localparam int SPAN_W      = OFFSET_W + LENGTH_W;
    localparam int NODE_DEPTH  = LAYERS * NODES_PER_LAYER;
    localparam int TRANS_DEPTH = LAYERS * TRANS_PER_LAYER;
    localparam int NODE_AW     = $clog2(NODE_DEPTH);
    localparam int TRANS_AW    = $clog2(TRANS_DEPTH);
    localparam int NODE_IDX_W  = $clog2(NODES_PER_LAYER);
    localparam int NEXT_W      = WORD_W - SYMBOL_BITS;
    localparam int TPOS_W      = $clog2(TRANS_PER_LAYER + 1);
    localparam int TIDX_W      = $clog2(TRANS_PER_LAYER);

    // Register port
    localparam int ROOT_W = 12;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_ROOT_IDX = '0;

    // Item op codes
    typedef enum logic [OP_W-1:0] {
        OP_NODE  = 2'd0,
        OP_TRANS = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    // Outcome of a walk
    typedef enum logic [1:0] {
        RES_ACCEPT  = 2'd0,
        RES_MISS    = 2'd1,
        RES_IDX_ERR = 2'd2
    } res_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic      start;
        logic      node_wr;
        logic      tw_wr;
        logic      node_rd;
        logic      span_load;
        logic      tw_rd_mid;
        logic      tw_rd_lo;
        logic      step;
        logic      next_layer;
        logic      set_res;
        res_kind_t res_kind;
        logic      out_load;
    } lmdd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic node_oor;
        logic lo_lt_hi;
        logic lo_ge_end;
        logic sym_lt;
        logic sym_eq;
        logic last_layer;
        logic out_free;
    } lmdd_stat_t;

endpackage

FILE: src/lmdd_if.sv
// ============================================================================
// lmdd_if: valid/ready channels for items and results
// One interface per channel, each with a source and a sink modport.
// ============================================================================
interface lmdd_item_if;
    import lmdd_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [LAYER_W-1:0]  layer;
    logic [ENTRY_W-1:0]  entry_index;
    logic [OFFSET_W-1:0] span_offset;
    logic [LENGTH_W-1:0] span_length;
    logic [WORD_W-1:0]   transition_word;
    logic [POS_W-1:0]    position;

    modport source (output valid, op, layer, entry_index, span_offset, span_length,
                    transition_word, position, input ready);
    modport sink   (input valid, op, layer, entry_index, span_offset, span_length,
                    transition_word, position, output ready);
endinterface

interface lmdd_result_if;
    import lmdd_pkg::*;

    logic              valid;
    logic              ready;
    logic              accepted;
    logic [FAIL_W-1:0] fail_layer;
    logic              index_error;

    modport source (output valid, accepted, fail_layer, index_error, input ready);
    modport sink   (input valid, accepted, fail_layer, index_error, output ready);
endinterface

FILE: src/layered_mdd_membership_lookup_core.sv
// ============================================================================
// layered_mdd_membership_lookup_core: decision-diagram membership lookup
// Top level joining the walk sequencer and the table datapath.
// ============================================================================
// Load items (node entry, transition word) are written in the cycle they are
// taken, so loads stream at one per cycle. A query holds the input off until
// its walk is done. Each layer visited runs these steps: the node index
// check with the node-table read, the span load, k binary-search probes
// (each a registered read of the transition RAM, then a compare), and a
// last read at the lower bound followed by its symbol check. Here
// k = ceil(log2(span_length+1)), at most 15 once the span is clamped to the
// table. A walk stops early on a miss or an index error. The result is then
// handed to the output register, and the next item can be taken in the
// cycle after that. The hand-off waits while the output register still
// holds a result that has not been taken. Both tables power up undefined
// and need no clearing pass; every entry must be loaded before a walk
// reads it. root_node sits at byte address 0 of the register port.
module layered_mdd_membership_lookup_core (
    input  logic                          clk,
    input  logic                          rst_n,
    lmdd_item_if.sink                     item_ch,
    lmdd_result_if.source                 result_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lmdd_pkg::APB_AW-1:0]   paddr,
    input  logic [lmdd_pkg::APB_DW-1:0]   pwdata,
    output logic [lmdd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import lmdd_pkg::*;

    lmdd_cmd_t  cmd;
    lmdd_stat_t stat;
    logic       ready;

    assign item_ch.ready = ready;

    // sequencer
    lmdd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_ch.valid),
        .item_op    (item_ch.op),
        .item_ready (ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // tables and walk registers
    lmdd_datapath u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .item_layer           (item_ch.layer),
        .item_entry_index     (item_ch.entry_index),
        .item_span_offset     (item_ch.span_offset),
        .item_span_length     (item_ch.span_length),
        .item_transition_word (item_ch.transition_word),
        .item_position        (item_ch.position),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .cmd                  (cmd),
        .stat                 (stat),
        .result_ch            (result_ch)
    );

endmodule

FILE: src/lmdd_ram.sv
// ============================================================================
// lmdd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module lmdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/lmdd_ctrl.sv
// ============================================================================
// lmdd_ctrl: walk sequencer
// Takes items, then steps a query through node fetch, binary search and
// transition check for each layer, and hands the result to the output stage.
// ============================================================================
module lmdd_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  logic [lmdd_pkg::OP_W-1:0] item_op,
    output logic                     item_ready,
    input  lmdd_pkg::lmdd_stat_t     stat,
    output lmdd_pkg::lmdd_cmd_t      cmd
);
    import lmdd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_NODE   = 7'b0000010,
        S_SPAN   = 7'b0000100,
        S_SEARCH = 7'b0001000,
        S_CMP    = 7'b0010000,
        S_MATCH  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   take;

    assign item_ready = (state_reg == S_IDLE);
    assign take       = item_valid && item_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_kind = RES_MISS;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (item_op)
                        OP_NODE:  cmd.node_wr = 1'b1;
                        OP_TRANS: cmd.tw_wr = 1'b1;
                        OP_QUERY:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_NODE;
                        end
                        default: ;
                    endcase
                end
            end
            S_NODE:
            begin
                if (stat.node_oor)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_IDX_ERR;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.node_rd = 1'b1;
                    state_next  = S_SPAN;
                end
            end
            S_SPAN:
            begin
                cmd.span_load = 1'b1;
                state_next    = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (stat.lo_lt_hi)
                begin
                    cmd.tw_rd_mid = 1'b1;
                    state_next    = S_CMP;
                end
                else if (stat.lo_ge_end)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_MISS;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.tw_rd_lo = 1'b1;
                    state_next   = S_MATCH;
                end
            end
            S_CMP:
            begin
                cmd.step   = 1'b1;
                state_next = S_SEARCH;
            end
            S_MATCH:
            begin
                if (stat.sym_eq)
                begin
                    cmd.next_layer = 1'b1;
                    if (stat.last_layer)
                    begin
                        cmd.set_res  = 1'b1;
                        cmd.res_kind = RES_ACCEPT;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_NODE;
                    end
                end
                else
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_MISS;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/lmdd_datapath.sv
// ============================================================================
// lmdd_datapath: tables, search registers and result stage
// Holds the node and transition RAMs, the root register, the walk
// registers (node, symbols, search bounds) and the output register.
// ============================================================================
module lmdd_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    // item payload
    input  logic [lmdd_pkg::LAYER_W-1:0]   item_layer,
    input  logic [lmdd_pkg::ENTRY_W-1:0]   item_entry_index,
    input  logic [lmdd_pkg::OFFSET_W-1:0]  item_span_offset,
    input  logic [lmdd_pkg::LENGTH_W-1:0]  item_span_length,
    input  logic [lmdd_pkg::WORD_W-1:0]    item_transition_word,
    input  logic [lmdd_pkg::POS_W-1:0]     item_position,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lmdd_pkg::APB_AW-1:0]    paddr,
    input  logic [lmdd_pkg::APB_DW-1:0]    pwdata,
    output logic [lmdd_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    // controller
    input  lmdd_pkg::lmdd_cmd_t            cmd,
    output lmdd_pkg::lmdd_stat_t           stat,
    // results
    lmdd_result_if.source                  result_ch
);
    import lmdd_pkg::*;

    logic [ROOT_W-1:0]  root_reg;
    logic [NEXT_W-1:0]  node_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [FAIL_W-1:0]  layer_reg;
    logic [TPOS_W-1:0]  lo_reg, hi_reg, end_reg;
    res_kind_t          res_reg;
    logic               out_valid_reg;
    logic               out_acc_reg;
    logic [FAIL_W-1:0]  out_fail_reg;
    logic               out_err_reg;

    logic                node_we, tw_we, tw_re;
    logic [NODE_AW-1:0]  node_waddr, node_raddr;
    logic [TRANS_AW-1:0] tw_waddr, tw_raddr;
    logic [SPAN_W-1:0]   span_rd;
    logic [WORD_W-1:0]   tw_rd;
    logic [TPOS_W:0]     span_sum, mid_sum;
    logic [TPOS_W-1:0]   span_lo, span_end, mid;
    logic [TIDX_W-1:0]   tw_idx;
    logic                reg_hit, cfg_wr;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_AW-1:2] == REG_ROOT_IDX);
    assign cfg_wr  = psel && penable && pwrite && reg_hit;
    assign prdata  = reg_hit ? APB_DW'(root_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
        end
        else if (cfg_wr)
        begin
            root_reg <= pwdata[ROOT_W-1:0];
        end
    end

    // ---------------- table loads ----------------
    assign node_we = cmd.node_wr && (32'(item_layer) < LAYERS)
                     && (32'(item_entry_index) < NODES_PER_LAYER);
    assign tw_we   = cmd.tw_wr && (32'(item_layer) < LAYERS)
                     && (32'(item_entry_index) < TRANS_PER_LAYER);
    assign node_waddr = NODE_AW'(item_layer) * NODE_AW'(NODES_PER_LAYER)
                        + NODE_AW'(item_entry_index);
    assign tw_waddr   = TRANS_AW'(item_layer) * TRANS_AW'(TRANS_PER_LAYER)
                        + TRANS_AW'(item_entry_index);

    // ---------------- read addresses ----------------
    assign node_raddr = NODE_AW'(layer_reg) * NODE_AW'(NODES_PER_LAYER)
                        + NODE_AW'(node_reg[NODE_IDX_W-1:0]);

    // midpoint of the open search range
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[TPOS_W:1];
    assign tw_idx  = cmd.tw_rd_lo ? lo_reg[TIDX_W-1:0] : mid[TIDX_W-1:0];
    assign tw_re   = cmd.tw_rd_mid || cmd.tw_rd_lo;
    assign tw_raddr = TRANS_AW'(layer_reg) * TRANS_AW'(TRANS_PER_LAYER)
                      + TRANS_AW'(tw_idx);

    lmdd_ram #(.WIDTH(SPAN_W), .DEPTH(NODE_DEPTH)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata ({item_span_length, item_span_offset}),
        .re    (cmd.node_rd),
        .raddr (node_raddr),
        .rdata (span_rd)
    );

    lmdd_ram #(.WIDTH(WORD_W), .DEPTH(TRANS_DEPTH)) u_trans_ram (
        .clk   (clk),
        .we    (tw_we),
        .waddr (tw_waddr),
        .wdata (item_transition_word),
        .re    (tw_re),
        .raddr (tw_raddr),
        .rdata (tw_rd)
    );

    // span bounds, both clamped to the table size
    assign span_sum = (TPOS_W+1)'(span_rd[OFFSET_W-1:0])
                      + (TPOS_W+1)'(span_rd[SPAN_W-1:OFFSET_W]);
    assign span_end = (span_sum > (TPOS_W+1)'(TRANS_PER_LAYER))
                      ? TPOS_W'(TRANS_PER_LAYER) : span_sum[TPOS_W-1:0];
    assign span_lo  = (TPOS_W'(span_rd[OFFSET_W-1:0]) > TPOS_W'(TRANS_PER_LAYER))
                      ? TPOS_W'(TRANS_PER_LAYER) : TPOS_W'(span_rd[OFFSET_W-1:0]);

    // ---------------- status ----------------
    assign stat.node_oor   = (node_reg >= NEXT_W'(NODES_PER_LAYER));
    assign stat.lo_lt_hi   = (lo_reg < hi_reg);
    assign stat.lo_ge_end  = (lo_reg >= end_reg);
    assign stat.sym_lt     = (tw_rd[SYMBOL_BITS-1:0] < pos_reg[SYMBOL_BITS-1:0]);
    assign stat.sym_eq     = (tw_rd[SYMBOL_BITS-1:0] == pos_reg[SYMBOL_BITS-1:0]);
    assign stat.last_layer = (layer_reg == FAIL_W'(LAYERS - 1));
    assign stat.out_free   = !out_valid_reg || result_ch.ready;

    // ---------------- walk registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            node_reg <= NEXT_W'(root_reg);
            pos_reg  <= item_position;
        end
        else if (cmd.next_layer)
        begin
            node_reg <= tw_rd[WORD_W-1:SYMBOL_BITS];
            pos_reg  <= pos_reg >> ROW_STRIDE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_reg <= '0;
        end
        else if (cmd.start)
        begin
            layer_reg <= '0;
        end
        else if (cmd.next_layer)
        begin
            layer_reg <= layer_reg + 1'b1;
        end
    end

    // search bounds
    always_ff @(posedge clk)
    begin
        if (cmd.span_load)
        begin
            lo_reg  <= span_lo;
            hi_reg  <= span_end;
            end_reg <= span_end;
        end
        else if (cmd.step)
        begin
            if (stat.sym_lt)
            begin
                lo_reg <= mid + 1'b1;
            end
            else
            begin
                hi_reg <= mid;
            end
        end
    end

    // pending outcome
    always_ff @(posedge clk)
    begin
        if (cmd.set_res)
        begin
            res_reg <= cmd.res_kind;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_fail_reg <= layer_reg;
            case (res_reg)
                RES_ACCEPT:
                begin
                    out_acc_reg <= 1'b1;
                    out_err_reg <= 1'b0;
                end
                RES_IDX_ERR:
                begin
                    out_acc_reg <= 1'b0;
                    out_err_reg <= 1'b1;
                end
                default:
                begin
                    out_acc_reg <= 1'b0;
                    out_err_reg <= 1'b0;
                end
            endcase
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.accepted    = out_acc_reg;
    assign result_ch.fail_layer  = out_fail_reg;
    assign result_ch.index_error = out_err_reg;

endmodule

FILE: src/lmdd_checker.sv
// ============================================================================
// lmdd_checker: port-level checks for the MDD lookup core
// Watches the item and result channels; bound to the top level below.
// ============================================================================
module lmdd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic [lmdd_pkg::OP_W-1:0]    item_op,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic                         res_accepted,
    input logic [lmdd_pkg::FAIL_W-1:0]  res_fail_layer,
    input logic                         res_index_error
);
    import lmdd_pkg::*;

    // a taken query keeps the block busy in the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item_op == OP_QUERY) |=> !item_ready)
        else $error("item taken right after a query");

    // an accepted walk reports the full depth and no index error
    a_accept_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_accepted) |->
            (res_fail_layer == FAIL_W'(LAYERS)) && !res_index_error)
        else $error("accepted result with failure fields");

    // a rejected walk stops inside the diagram
    a_reject_layer: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_accepted) |-> (res_fail_layer < FAIL_W'(LAYERS)))
        else $error("rejected result beyond last layer");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(res_accepted) && $stable(res_fail_layer)
             && $stable(res_index_error)))
        else $error("stalled result changed");

endmodule

bind layered_mdd_membership_lookup_core lmdd_checker u_lmdd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_ch.valid),
    .item_ready      (item_ch.ready),
    .item_op         (item_ch.op),
    .res_valid       (result_ch.valid),
    .res_ready       (result_ch.ready),
    .res_accepted    (result_ch.accepted),
    .res_fail_layer  (result_ch.fail_layer),
    .res_index_error (result_ch.index_error)
);

FILE: sim/tb.sv
// ============================================================================
// tb: testbench for layered_mdd_membership_lookup_core
// Loads layered decision diagrams through the item channel and sends lookups
// whose walks touch loaded entries only. A scoreboard mirrors both tables and
// root_node, works out each lookup's verdict and compares it with the
// returned item, field by field. Both channels idle at random, the result
// side also holds off for a long stretch, and root_node is rewritten between
// phases.
// ============================================================================
module tb;
    import lmdd_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int DRAIN_LIMIT    = 50_000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int HOLD_CYCLES    = 1500;
    localparam int MIX_PER_PHASE  = 90;
    localparam int SYM_MAX        = (1 << SYMBOL_BITS) - 1;
    localparam int LAYER_MAX      = (1 << LAYER_W) - 1;
    localparam int ENTRY_MAX      = (1 << ENTRY_W) - 1;

    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [APB_AW-1:0] ROOT_ADDR = {REG_ROOT_IDX, 2'b00};

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [LAYER_W-1:0]  layer;
        logic [ENTRY_W-1:0]  entry_index;
        logic [OFFSET_W-1:0] span_offset;
        logic [LENGTH_W-1:0] span_length;
        logic [WORD_W-1:0]   transition_word;
        logic [POS_W-1:0]    position;
    } lookup_item_t;

    typedef struct packed {
        logic              accepted;
        logic [FAIL_W-1:0] fail_layer;
        logic              index_error;
    } verdict_t;

    // Mirror of both tables plus the queue of verdicts still owed
    class membership_scoreboard;
        bit [SPAN_W-1:0] span_mem    [NODE_DEPTH];
        bit              span_loaded [NODE_DEPTH];
        bit [WORD_W-1:0] word_mem    [TRANS_DEPTH];
        bit              word_loaded [TRANS_DEPTH];
        logic [ROOT_W-1:0] root;
        verdict_t pending_verdicts [$];
        int mismatches;

        function new();
            root = '0;
            mismatches = 0;
        endfunction

        function void set_root(input logic [ROOT_W-1:0] value);
            root = value;
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        // Walk from root; returns 0 when any read hits an entry never loaded
        function bit walk_diagram(input logic [POS_W-1:0] pos, output verdict_t v);
            int unsigned node, na, wa, lo, hi, fin, mid;
            logic [SPAN_W-1:0] span;
            logic [SYMBOL_BITS-1:0] sym;
            bit defined;
            defined = 1'b1;
            node = root;
            for (int d = 0; d < LAYERS; d++)
            begin
                if (node >= NODES_PER_LAYER)
                begin
                    v = '{accepted: 1'b0, fail_layer: FAIL_W'(d), index_error: 1'b1};
                    return defined;
                end
                sym = pos[d*ROW_STRIDE +: SYMBOL_BITS];
                na = d * NODES_PER_LAYER + node;
                defined &= span_loaded[na];
                span = span_mem[na];
                lo = span[OFFSET_W-1:0];
                fin = lo + span[SPAN_W-1:OFFSET_W];
                if (fin > TRANS_PER_LAYER)
                    fin = TRANS_PER_LAYER;
                hi = fin;
                // lower-bound search for the row symbol
                while (lo < hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    wa = d * TRANS_PER_LAYER + mid;
                    defined &= word_loaded[wa];
                    if (word_mem[wa][SYMBOL_BITS-1:0] < sym)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (lo >= fin)
                begin
                    v = '{accepted: 1'b0, fail_layer: FAIL_W'(d), index_error: 1'b0};
                    return defined;
                end
                wa = d * TRANS_PER_LAYER + lo;
                defined &= word_loaded[wa];
                if (word_mem[wa][SYMBOL_BITS-1:0] != sym)
                begin
                    v = '{accepted: 1'b0, fail_layer: FAIL_W'(d), index_error: 1'b0};
                    return defined;
                end
                node = word_mem[wa][WORD_W-1:SYMBOL_BITS];
            end
            v = '{accepted: 1'b1, fail_layer: FAIL_W'(LAYERS), index_error: 1'b0};
            return defined;
        endfunction

        // Apply an accepted item; returns 1 when the block acts on it
        function bit note_item(input lookup_item_t it);
            verdict_t v;
            int unsigned a;
            case (it.op)
                OP_NODE:
                begin
                    if (it.layer < LAYERS && it.entry_index < NODES_PER_LAYER)
                    begin
                        a = int'(it.layer) * NODES_PER_LAYER + int'(it.entry_index);
                        span_mem[a] = {it.span_length, it.span_offset};
                        span_loaded[a] = 1'b1;
                        return 1'b1;
                    end
                end
                OP_TRANS:
                begin
                    if (it.layer < LAYERS)
                    begin
                        a = int'(it.layer) * TRANS_PER_LAYER + int'(it.entry_index);
                        word_mem[a] = it.transition_word;
                        word_loaded[a] = 1'b1;
                        return 1'b1;
                    end
                end
                OP_QUERY:
                begin
                    void'(walk_diagram(it.position, v));
                    pending_verdicts.insert(pending_verdicts.size(), v);
                    return 1'b1;
                end
                default: ;
            endcase
            return 1'b0;
        endfunction

        function void check_verdict(input verdict_t got);
            verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                $error("result item with no lookup outstanding");
                mismatches++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.accepted !== want.accepted)
            begin
                $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                mismatches++;
            end
            if (got.fail_layer !== want.fail_layer)
            begin
                $error("fail_layer: expected %0d, got %0d", want.fail_layer, got.fail_layer);
                mismatches++;
            end
            if (got.index_error !== want.index_error)
            begin
                $error("index_error: expected %0d, got %0d", want.index_error,
                       got.index_error);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    lmdd_item_if   item_ch ();
    lmdd_result_if result_ch ();

    membership_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int items_taken;
    bit hold_req;

    layered_mdd_membership_lookup_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .result_ch (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("layered_mdd_membership_lookup_core: mismatch");
        $finish;
    end

    // Result side: random ready, plus one long hold-off on request
    initial
    begin
        bit hold_seen;
        int hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready = 1'b0;
            end
            else
                result_ch.ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Result monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_verdict('{accepted: result_ch.accepted,
                                   fail_layer: result_ch.fail_layer,
                                   index_error: result_ch.index_error});
        end
    end

    function automatic lookup_item_t random_item();
        lookup_item_t it;
        it.op              = OP_W'($urandom);
        it.layer           = LAYER_W'($urandom);
        it.entry_index     = ENTRY_W'($urandom);
        it.span_offset     = OFFSET_W'($urandom);
        it.span_length     = LENGTH_W'($urandom);
        it.transition_word = $urandom;
        it.position        = POS_W'({$urandom, $urandom});
        return it;
    endfunction

    // Offer one item at the falling edge and hold it until taken
    task automatic send_item(input lookup_item_t it);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.op              = it.op;
        item_ch.layer           = it.layer;
        item_ch.entry_index     = it.entry_index;
        item_ch.span_offset     = it.span_offset;
        item_ch.span_length     = it.span_length;
        item_ch.transition_word = it.transition_word;
        item_ch.position        = it.position;
        item_ch.valid           = 1'b1;
        do @(posedge clk); while (!item_ch.ready);
        if (sb.note_item(it))
            items_taken++;
        @(negedge clk);
    endtask

    task automatic load_node(input int unsigned layer, input int unsigned idx,
                             input int unsigned off, input int unsigned len);
        lookup_item_t it;
        it = random_item();
        it.op          = OP_NODE;
        it.layer       = LAYER_W'(layer);
        it.entry_index = ENTRY_W'(idx);
        it.span_offset = OFFSET_W'(off);
        it.span_length = LENGTH_W'(len);
        send_item(it);
    endtask

    task automatic load_word(input int unsigned layer, input int unsigned idx,
                             input logic [WORD_W-1:0] word);
        lookup_item_t it;
        it = random_item();
        it.op              = OP_TRANS;
        it.layer           = LAYER_W'(layer);
        it.entry_index     = ENTRY_W'(idx);
        it.transition_word = word;
        send_item(it);
    endtask

    task automatic query(input logic [POS_W-1:0] pos);
        lookup_item_t it;
        it = random_item();
        it.op       = OP_QUERY;
        it.position = pos;
        send_item(it);
    endtask

    // Occasional item the block must ignore: unused op or out-of-range write
    task automatic scatter_noise();
        lookup_item_t it;
        if ($urandom_range(0, 24) != 0)
            return;
        it = random_item();
        case ($urandom_range(0, 2))
            0: it.op = OP_UNUSED;
            1:
            begin
                it.op = OP_NODE;
                if ($urandom_range(0, 1) == 0)
                    it.layer = LAYER_W'($urandom_range(LAYERS, LAYER_MAX));
                else
                    it.entry_index = ENTRY_W'($urandom_range(NODES_PER_LAYER, ENTRY_MAX));
            end
            default:
            begin
                it.op = OP_TRANS;
                it.layer = LAYER_W'($urandom_range(LAYERS, LAYER_MAX));
            end
        endcase
        send_item(it);
    endtask

    // Follow loaded transitions most of the way, random symbols elsewhere
    function automatic logic [POS_W-1:0] pick_position();
        logic [POS_W-1:0] pos;
        logic [SPAN_W-1:0] span;
        int unsigned node, na, off, fin, wa;
        pos = POS_W'({$urandom, $urandom});
        node = sb.root;
        for (int d = 0; d < LAYERS; d++)
        begin
            if (node >= NODES_PER_LAYER)
                break;
            na = d * NODES_PER_LAYER + node;
            if (!sb.span_loaded[na])
                break;
            span = sb.span_mem[na];
            off = span[OFFSET_W-1:0];
            fin = off + span[SPAN_W-1:OFFSET_W];
            if (fin > TRANS_PER_LAYER)
                fin = TRANS_PER_LAYER;
            if (fin <= off || $urandom_range(0, 11) == 0)
                break;
            wa = d * TRANS_PER_LAYER + $urandom_range(off, fin - 1);
            if (!sb.word_loaded[wa])
                break;
            pos[d*ROW_STRIDE +: SYMBOL_BITS] = sb.word_mem[wa][SYMBOL_BITS-1:0];
            node = sb.word_mem[wa][WORD_W-1:SYMBOL_BITS];
        end
        return pos;
    endfunction

    // Send a lookup whose walk reads loaded entries only, if one is found
    task automatic send_lookup();
        logic [POS_W-1:0] pos;
        verdict_t v;
        for (int t = 0; t < 8; t++)
        begin
            pos = pick_position();
            if (sb.walk_diagram(pos, v))
            begin
                query(pos);
                return;
            end
        end
    endtask

    // Load a fresh diagram: a few nodes per layer, each with a sorted span
    task automatic build_diagram(output logic [ROOT_W-1:0] root_pick);
        int unsigned layer_nodes [LAYERS][$];
        int unsigned span_lens [$];
        logic [SYMBOL_BITS-1:0] syms [$];
        int unsigned total, offset, next_node, r;
        for (int d = 0; d < LAYERS; d++)
        begin
            repeat ($urandom_range(1, 4))
                layer_nodes[d].insert(layer_nodes[d].size(),
                                      $urandom_range(0, NODES_PER_LAYER - 1));
            r = $urandom_range(0, 5);
            if (r == 0)
                layer_nodes[d].insert(layer_nodes[d].size(), 0);
            else if (r == 1)
                layer_nodes[d].insert(layer_nodes[d].size(), NODES_PER_LAYER - 1);
        end
        for (int d = 0; d < LAYERS; d++)
        begin
            span_lens.delete();
            total = 0;
            for (int n = 0; n < layer_nodes[d].size(); n++)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    span_lens.insert(span_lens.size(), 0);
                else if (r == 1)
                    span_lens.insert(span_lens.size(), $urandom_range(16, 60));
                else
                    span_lens.insert(span_lens.size(), $urandom_range(1, 6));
                total += span_lens[n];
            end
            offset = $urandom_range(0, TRANS_PER_LAYER - total);
            for (int n = 0; n < layer_nodes[d].size(); n++)
            begin
                syms.delete();
                repeat (span_lens[n])
                    syms.insert(syms.size(), SYMBOL_BITS'($urandom_range(0, SYM_MAX)));
                syms.sort();
                for (int k = 0; k < syms.size(); k++)
                begin
                    // last layer: next index is never checked
                    if (d == LAYERS - 1)
                        next_node = $urandom_range(0, (1 << NEXT_W) - 1);
                    else if ($urandom_range(0, 19) == 0)
                        next_node = $urandom_range(NODES_PER_LAYER, (1 << NEXT_W) - 1);
                    else
                        next_node = layer_nodes[d+1][$urandom_range(0,
                                                    layer_nodes[d+1].size() - 1)];
                    load_word(d, offset + k, {NEXT_W'(next_node), syms[k]});
                    scatter_noise();
                end
                load_node(d, layer_nodes[d][n], offset, span_lens[n]);
                scatter_noise();
                offset += span_lens[n];
            end
        end
        root_pick = ROOT_W'(layer_nodes[0][$urandom_range(0, layer_nodes[0].size() - 1)]);
    endtask

    // Stop offering items and wait for every owed verdict
    task automatic wait_drained();
        item_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // APB write of root_node, then read back
    task automatic write_root(input logic [ROOT_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ROOT_ADDR;
        pwdata  = APB_DW'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        psel = 1'b1;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== APB_DW'(value))
        begin
            $error("root_node read back: expected %0h, got %0h", value, prdata);
            sb.mismatches++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        sb.set_root(value);
    endtask

    initial
    begin
        logic [ROOT_W-1:0] root_pick;
        lookup_item_t it;
        int phase_no;
        int waited;
        int r;

        sb = new();
        rst_n       = 1'b0;
        tx_idle_pct = 22;
        rx_idle_pct = 74;
        items_taken = 0;
        hold_req    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        item_ch.valid           = 1'b0;
        item_ch.op              = '0;
        item_ch.layer           = '0;
        item_ch.entry_index     = '0;
        item_ch.span_offset     = '0;
        item_ch.span_length     = '0;
        item_ch.transition_word = '0;
        item_ch.position        = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a chain of single-word spans, symbol 0 to node 0 everywhere
        write_root('0);
        for (int d = 0; d < LAYERS; d++)
        begin
            load_word(d, 0, '0);
            load_node(d, 0, 0, 1);
        end
        query('0);
        query(POS_W'(1) << (3 * ROW_STRIDE));       // symbol missing in layer 3
        load_word(LAYERS - 1, 0, 32'hFFFF_FFC0);    // last layer's next is unchecked
        query('0);
        it = random_item();
        it.op = OP_UNUSED;
        send_item(it);
        load_node(LAYER_MAX, ENTRY_MAX, TRANS_PER_LAYER - 1, TRANS_PER_LAYER);
        load_node(0, NODES_PER_LAYER, 5, 0);         // node index past the store
        load_word(LAYER_MAX, ENTRY_MAX, '1);
        query('0);                                  // ignored writes changed nothing
        load_word(4, 0, 32'hFFFF_FFC0);             // next node beyond the store
        query('0);
        // span running past the table end is clamped to one word
        load_node(0, NODES_PER_LAYER - 1, TRANS_PER_LAYER - 1, TRANS_PER_LAYER);
        load_word(0, TRANS_PER_LAYER - 1, WORD_W'(SYM_MAX));
        wait_drained();
        write_root(ROOT_W'(NODES_PER_LAYER - 1));
        query(POS_W'(SYM_MAX));
        query(POS_W'(SYM_MAX - 1));
        query('1);
        wait_drained();

        // Random phases: load a diagram, set root, then lookups mixed with rewrites
        items_taken = 0;
        phase_no = 0;
        while (items_taken < RANDOM_ITEMS)
        begin
            if (items_taken < RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 22;
                rx_idle_pct = 74;
            end
            else if (items_taken < 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 74;
                rx_idle_pct = 22;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            build_diagram(root_pick);
            wait_drained();
            write_root(root_pick);
            if (phase_no == 1)
                hold_req = ~hold_req;
            repeat (MIX_PER_PHASE)
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    send_lookup();
                else if (r < 9)
                    load_word($urandom_range(0, LAYERS - 1),
                              $urandom_range(0, TRANS_PER_LAYER - 1), $urandom);
                else
                    load_node($urandom_range(0, LAYERS - 1),
                              $urandom_range(0, NODES_PER_LAYER - 1),
                              $urandom_range(0, TRANS_PER_LAYER - 1),
                              $urandom_range(0, TRANS_PER_LAYER));
                scatter_noise();
            end
            wait_drained();
            phase_no++;
        end

        // Wind down
        item_ch.valid = 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.pending() != 0)
            $error("%0d lookups never returned a result", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("layered_mdd_membership_lookup_core: match");
        else
            $display("layered_mdd_membership_lookup_core: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
src/lmdd_pkg.sv
src/lmdd_if.sv
src/lmdd_ram.sv
src/lmdd_ctrl.sv
src/lmdd_datapath.sv
src/layered_mdd_membership_lookup_core.sv
src/lmdd_checker.sv
sim/tb.sv
